// File: sv/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; each macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/arm_dp_pkg.sv
// types and constants for the data-processing execute block
// no dependencies
package arm_dp_pkg;

  localparam int unsigned NumRegs  = 16;
  localparam int unsigned RegIdxW  = 4;
  localparam int unsigned DataW    = 32;

  // alu opcodes, instruction bits 24:21
  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;

  // shift kinds, instruction bits 6:5
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // one result transaction, packed so the first field lands in the highest bits
  typedef struct packed {
    logic               flag_carry;
    logic               flag_zero;
    logic               flag_negative;
    logic [DataW-1:0]   write_value;
    logic [RegIdxW-1:0] dest_index;
    logic               write_enable;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

// File: sv/arm_data_processing_execute.sv
// arm data-processing execute stage with barrel shifter, uses arm_dp_pkg
// an accepted transaction is held in the execute stage registers, then in the result
// register on out_tdata; throughput: one instruction per cycle unless out_tready stalls;
// register read data is captured at acceptance, forwarded from the instruction executing
// in that cycle; reset: synchronous on rst_n low clears flags, register valid bits and
// handshake state; a register never written since reset reads as zero
`include "assert_macros.svh"

module arm_data_processing_execute (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // instruction[31:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // write_enable[0], dest_index[4:1], write_value[36:5],
  // flag_negative[37], flag_zero[38], flag_carry[39]
  output logic [arm_dp_pkg::ResultW-1:0] out_tdata
);
  import arm_dp_pkg::*;

  // handshake and stage control
  logic in_acc;
  logic adv;
  logic out_free;

  // execute stage registers
  logic                s1_valid_r;
  logic [31:0]         ins_r;
  logic [DataW-1:0]    rn_mem_r, rm_mem_r, rs_mem_r;
  logic                rn_ok_r, rm_ok_r, rs_ok_r;
  logic                rn_fwd_r, rm_fwd_r, rs_fwd_r;
  logic [DataW-1:0]    fwd_data_r;

  // register file: two copies so three operands can be read per transaction
  logic [DataW-1:0]    rf_a_mem [NumRegs];
  logic [DataW-1:0]    rf_b_mem [NumRegs];
  logic [NumRegs-1:0]  rf_vld_r;
  logic                rf_we;
  logic [RegIdxW-1:0]  rf_waddr;

  // flags
  logic neg_r, zero_r, carry_r;
  logic neg_nxt, zero_nxt, carry_nxt;

  // read addresses of the incoming transaction
  logic [RegIdxW-1:0] rn_addr, rm_addr, rs_addr;

  // execute datapath
  logic [DataW-1:0] rn_val, rm_val, rs_val;
  logic [3:0]       opcode;
  logic [7:0]       sh_amt;
  logic [4:0]       amt5;
  logic             sh_big;
  logic [32:0]      lsl_ext, lsr_ext, asr_ext;
  logic [DataW-1:0] ror_res, imm_res;
  logic [4:0]       rot5;
  logic [DataW-1:0] op2;
  logic             shc;
  logic [DataW-1:0] add_a, add_b;
  logic             add_cin;
  logic [32:0]      sum;
  logic [DataW-1:0] res;
  logic             arith;
  logic             wr;

  result_t          out_r;
  result_t          out_nxt;
  logic             out_valid_r;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign rn_addr = in_tdata[19:16];
  assign rm_addr = in_tdata[3:0];
  assign rs_addr = in_tdata[11:8];

  assign rf_we    = adv && wr;
  assign rf_waddr = ins_r[15:12];

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // operand capture with forwarding from the instruction retiring this cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ins_r      <= in_tdata;
      rn_mem_r   <= rf_a_mem[rn_addr];
      rm_mem_r   <= rf_a_mem[rm_addr];
      rs_mem_r   <= rf_b_mem[rs_addr];
      rn_ok_r    <= rf_vld_r[rn_addr];
      rm_ok_r    <= rf_vld_r[rm_addr];
      rs_ok_r    <= rf_vld_r[rs_addr];
      rn_fwd_r   <= rf_we && (rf_waddr == rn_addr);
      rm_fwd_r   <= rf_we && (rf_waddr == rm_addr);
      rs_fwd_r   <= rf_we && (rf_waddr == rs_addr);
      fwd_data_r <= res;
    end
  end

  // register file writes
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_a_mem[rf_waddr] <= res;
      rf_b_mem[rf_waddr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[rf_waddr] <= 1'b1;
    end
  end

  assign rn_val = rn_fwd_r ? fwd_data_r : (rn_ok_r ? rn_mem_r : '0);
  assign rm_val = rm_fwd_r ? fwd_data_r : (rm_ok_r ? rm_mem_r : '0);
  assign rs_val = rs_fwd_r ? fwd_data_r : (rs_ok_r ? rs_mem_r : '0);

  // barrel shifter
  always_comb begin
    sh_amt  = ins_r[4] ? rs_val[7:0] : {3'b000, ins_r[11:7]};
    amt5    = sh_amt[4:0];
    sh_big  = (sh_amt[7:5] != 3'b000);
    lsl_ext = {1'b0, rm_val} << amt5;
    lsr_ext = {rm_val, 1'b0} >> amt5;
    asr_ext = 33'($signed({rm_val, 1'b0}) >>> amt5);
    ror_res = 32'({rm_val, rm_val} >> amt5);
    rot5    = {ins_r[11:8], 1'b0};
    imm_res = 32'({24'b0, ins_r[7:0], 24'b0, ins_r[7:0]} >> rot5);
    op2     = rm_val;
    shc     = carry_r;
    if (ins_r[25]) begin
      op2 = imm_res;
      shc = (rot5 == 5'd0) ? carry_r : imm_res[31];
    end else if (sh_amt != 8'd0) begin
      case (ins_r[6:5])
        SH_LSL: begin
          if (!sh_big) begin
            {shc, op2} = lsl_ext;
          end else begin
            op2 = '0;
            shc = (sh_amt == 8'd32) ? rm_val[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (!sh_big) begin
            op2 = lsr_ext[32:1];
            shc = lsr_ext[0];
          end else begin
            op2 = '0;
            shc = (sh_amt == 8'd32) ? rm_val[31] : 1'b0;
          end
        end
        SH_ASR: begin
          if (!sh_big) begin
            op2 = asr_ext[32:1];
            shc = asr_ext[0];
          end else begin
            op2 = {DataW{rm_val[31]}};
            shc = rm_val[31];
          end
        end
        default: begin
          // ror by a multiple of 32 keeps the value, carry is bit 31
          if (amt5 == 5'd0) begin
            op2 = rm_val;
            shc = rm_val[31];
          end else begin
            op2 = ror_res;
            shc = ror_res[31];
          end
        end
      endcase
    end
  end

  // alu
  always_comb begin
    opcode  = ins_r[24:21];
    add_a   = rn_val;
    add_b   = ~op2;
    add_cin = 1'b1;
    if (opcode == OP_RSB) begin
      add_a = op2;
      add_b = ~rn_val;
    end else if (opcode == OP_ADD) begin
      add_b   = op2;
      add_cin = 1'b0;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};

    arith = 1'b0;
    wr    = 1'b1;
    unique case (opcode) inside
      OP_EOR: res = rn_val ^ op2;
      OP_SUB, OP_RSB, OP_ADD: begin
        res   = sum[31:0];
        arith = 1'b1;
      end
      OP_TST: begin
        res = rn_val & op2;
        wr  = 1'b0;
      end
      OP_TEQ: begin
        res = rn_val ^ op2;
        wr  = 1'b0;
      end
      OP_CMP: begin
        res   = sum[31:0];
        arith = 1'b1;
        wr    = 1'b0;
      end
      OP_ORR: res = rn_val | op2;
      OP_MOV: res = op2;
      default: res = rn_val & op2;
    endcase

    neg_nxt   = neg_r;
    zero_nxt  = zero_r;
    carry_nxt = carry_r;
    if (ins_r[20]) begin
      neg_nxt   = res[31];
      zero_nxt  = (res == '0);
      carry_nxt = arith ? sum[32] : shc;
    end

    out_nxt.write_enable  = wr;
    out_nxt.dest_index    = ins_r[15:12];
    out_nxt.write_value   = wr ? res : '0;
    out_nxt.flag_negative = neg_nxt;
    out_nxt.flag_zero     = zero_nxt;
    out_nxt.flag_carry    = carry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r   <= 1'b0;
      zero_r  <= 1'b0;
      carry_r <= 1'b0;
    end else if (adv) begin
      neg_r   <= neg_nxt;
      zero_r  <= zero_nxt;
      carry_r <= carry_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  `ASSERT_IMPL(a_wr_needs_stage, rf_we, s1_valid_r && out_free,
               "register write without an executing instruction")
  `ASSERT_NEXT(a_wr_sets_valid, rf_we, rf_vld_r[$past(rf_waddr)],
               "written register not marked valid")
  `ASSERT_NEXT(a_flags_hold, adv && !ins_r[20],
               $stable(neg_r) && $stable(zero_r) && $stable(carry_r),
               "flags changed without s bit")
  `ASSERT_IMPL(a_out_from_adv, $rose(out_valid_r), $past(adv),
               "result appeared without an executed instruction")
  `ASSERT_IMPL(a_nowrite_zero, out_valid_r && !out_r.write_enable, out_r.write_value == '0,
               "non-writing instruction carries a value")

endmodule

// File: bench/tb_arm_data_processing_execute.sv
`timescale 1ns / 100ps
// self-checking bench for arm_data_processing_execute: directed and random instructions
// under varied stream back-pressure; depends on arm_dp_pkg and the rtl top
module tb_arm_data_processing_execute;
  import arm_dp_pkg::*;

  localparam int unsigned HalfPeriod = 2;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 8;
  localparam logic [3:0]  COND_AL = 4'hE;
  // opcode outside the listed set, executes as and
  localparam logic [3:0]  OP_UNLISTED = 4'd15;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [31:0]         in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [ResultW-1:0]  out_tdata;

  // architectural state tracked by the bench
  logic [DataW-1:0] arch_regs [NumRegs];
  logic             flag_n = 1'b0;
  logic             flag_z = 1'b0;
  logic             flag_c = 1'b0;

  result_t     pending_results [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  arm_data_processing_execute u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #HalfPeriod clk = ~clk;

  function automatic logic [31:0] barrel_shift(input logic [1:0] kind, input logic [31:0] v,
                                               input int unsigned amt, output logic cout);
    int unsigned r;
    r = amt % 32;
    cout = flag_c;
    if (amt == 0) return v;
    case (kind)
      SH_LSL: begin
        if (amt < 32) begin
          cout = v[32-amt];
          return v << amt;
        end
        cout = (amt == 32) ? v[0] : 1'b0;
        return '0;
      end
      SH_LSR: begin
        if (amt < 32) begin
          cout = v[amt-1];
          return v >> amt;
        end
        cout = (amt == 32) ? v[31] : 1'b0;
        return '0;
      end
      SH_ASR: begin
        if (amt < 32) begin
          cout = v[amt-1];
          return $signed(v) >>> amt;
        end
        cout = v[31];
        return {32{v[31]}};
      end
      default: begin
        // multiples of 32 keep the value, carry from the sign bit
        if (r == 0) begin
          cout = v[31];
          return v;
        end
        cout = v[r-1];
        return (v >> r) | (v << (32 - r));
      end
    endcase
  endfunction

  // executes one instruction on the tracked state and returns its result transaction
  function automatic result_t exec_predict(input logic [31:0] w);
    logic [3:0]  op;
    logic [3:0]  rd;
    logic [31:0] a, b, res, imm32;
    logic [32:0] sum;
    logic        shc, addc, arith, wr;
    int unsigned rot, amt;
    result_t     r;
    op = w[24:21];
    rd = w[15:12];
    a = arch_regs[w[19:16]];
    if (w[25]) begin
      rot = {w[11:8], 1'b0};
      imm32 = {24'b0, w[7:0]};
      b = (rot == 0) ? imm32 : ((imm32 >> rot) | (imm32 << (32 - rot)));
      shc = (rot == 0) ? flag_c : b[31];
    end else begin
      amt = w[4] ? int'(arch_regs[w[11:8]][7:0]) : int'(w[11:7]);
      b = barrel_shift(w[6:5], arch_regs[w[3:0]], amt, shc);
    end
    arith = 1'b0;
    addc = 1'b0;
    wr = 1'b1;
    case (op)
      OP_EOR: res = a ^ b;
      OP_SUB: begin
        res = a - b; arith = 1'b1; addc = (a >= b);
      end
      OP_RSB: begin
        res = b - a; arith = 1'b1; addc = (b >= a);
      end
      OP_ADD: begin
        sum = {1'b0, a} + {1'b0, b}; res = sum[31:0]; arith = 1'b1; addc = sum[32];
      end
      OP_TST: begin
        res = a & b; wr = 1'b0;
      end
      OP_TEQ: begin
        res = a ^ b; wr = 1'b0;
      end
      OP_CMP: begin
        res = a - b; arith = 1'b1; addc = (a >= b); wr = 1'b0;
      end
      OP_ORR: res = a | b;
      OP_MOV: res = b;
      default: res = a & b;
    endcase
    if (wr) arch_regs[rd] = res;
    if (w[20]) begin
      flag_n = res[31];
      flag_z = (res == '0);
      flag_c = arith ? addc : shc;
    end
    r.write_enable = wr;
    r.dest_index = rd;
    r.write_value = wr ? res : '0;
    r.flag_negative = flag_n;
    r.flag_zero = flag_z;
    r.flag_carry = flag_c;
    return r;
  endfunction

  function automatic logic [31:0] enc_imm(input logic [3:0] op, input logic s,
                                          input logic [3:0] rn, input logic [3:0] rd,
                                          input logic [3:0] rot, input logic [7:0] imm);
    return {COND_AL, 2'b00, 1'b1, op, s, rn, rd, rot, imm};
  endfunction

  function automatic logic [31:0] enc_shi(input logic [3:0] op, input logic s,
                                          input logic [3:0] rn, input logic [3:0] rd,
                                          input logic [4:0] amt, input logic [1:0] kind,
                                          input logic [3:0] rm);
    return {COND_AL, 2'b00, 1'b0, op, s, rn, rd, amt, kind, 1'b0, rm};
  endfunction

  function automatic logic [31:0] enc_shr(input logic [3:0] op, input logic s,
                                          input logic [3:0] rn, input logic [3:0] rd,
                                          input logic [3:0] rs, input logic [1:0] kind,
                                          input logic [3:0] rm);
    return {COND_AL, 2'b00, 1'b0, op, s, rn, rd, rs, 1'b0, kind, 1'b1, rm};
  endfunction

  task automatic send_instr(input logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(exec_predict(w));
  endtask

  task automatic test_reset_state();
    send_instr(enc_shi(OP_ADD, 1'b1, 4'd1, 4'd0, 5'd0, SH_LSL, 4'd2));
    send_instr(enc_shr(OP_MOV, 1'b1, 4'd0, 4'd3, 4'd5, SH_ROR, 4'd4));
  endtask

  task automatic test_immediate_rotate();
    send_instr(enc_imm(OP_MOV, 1'b1, 4'd0, 4'd1, 4'd0, 8'hFF));
    send_instr(enc_imm(OP_MOV, 1'b1, 4'd0, 4'd2, 4'd1, 8'h01));
    send_instr(enc_imm(OP_MOV, 1'b1, 4'd0, 4'd3, 4'd1, 8'h02));
    send_instr(enc_imm(OP_MOV, 1'b1, 4'd0, 4'd4, 4'd4, 8'hFF));
  endtask

  task automatic test_alu_ops();
    send_instr(enc_shi(OP_AND, 1'b1, 4'd1, 4'd5, 5'd0, SH_LSL, 4'd4));
    send_instr(enc_shi(OP_EOR, 1'b1, 4'd3, 4'd6, 5'd0, SH_LSL, 4'd4));
    send_instr(enc_shi(OP_SUB, 1'b1, 4'd1, 4'd7, 5'd0, SH_LSL, 4'd4));
    send_instr(enc_shi(OP_RSB, 1'b1, 4'd1, 4'd8, 5'd0, SH_LSL, 4'd4));
    send_instr(enc_shi(OP_ADD, 1'b1, 4'd3, 4'd9, 5'd0, SH_LSL, 4'd3));
    send_instr(enc_shi(OP_TST, 1'b1, 4'd4, 4'd2, 5'd0, SH_LSL, 4'd3));
    send_instr(enc_shi(OP_TEQ, 1'b1, 4'd4, 4'd2, 5'd0, SH_LSL, 4'd4));
    send_instr(enc_shi(OP_CMP, 1'b1, 4'd1, 4'd2, 5'd0, SH_LSL, 4'd1));
    send_instr(enc_shi(OP_ORR, 1'b1, 4'd1, 4'd10, 5'd0, SH_LSL, 4'd3));
    send_instr(enc_shi(OP_MOV, 1'b0, 4'd0, 4'd11, 5'd0, SH_LSL, 4'd4));
    send_instr(enc_shi(OP_UNLISTED, 1'b1, 4'd4, 4'd12, 5'd0, SH_LSL, 4'd4));
  endtask

  task automatic test_shifter();
    send_instr(enc_imm(OP_MOV, 1'b0, 4'd0, 4'd12, 4'd0, 8'd32));
    send_instr(enc_imm(OP_MOV, 1'b0, 4'd0, 4'd13, 4'd0, 8'd33));
    send_instr(enc_shr(OP_MOV, 1'b1, 4'd0, 4'd0, 4'd12, SH_LSR, 4'd3));
    send_instr(enc_shr(OP_MOV, 1'b1, 4'd0, 4'd0, 4'd13, SH_ASR, 4'd4));
    send_instr(enc_shr(OP_MOV, 1'b1, 4'd0, 4'd0, 4'd12, SH_ROR, 4'd1));
    send_instr(enc_shr(OP_MOV, 1'b1, 4'd0, 4'd0, 4'd13, SH_LSL, 4'd1));
    send_instr(enc_shi(OP_MOV, 1'b1, 4'd0, 4'd0, 5'd31, SH_LSL, 4'd1));
    send_instr(enc_shi(OP_MOV, 1'b1, 4'd0, 4'd0, 5'd1, SH_ASR, 4'd3));
    send_instr(enc_shi(OP_MOV, 1'b1, 4'd0, 4'd0, 5'd4, SH_ROR, 4'd1));
  endtask

  task automatic test_ignored_bits();
    logic [31:0] w;
    // condition 0, bits 27:26 set, bit 7 set in register-shift form, rn nonzero for mov
    w = enc_shr(OP_MOV, 1'b1, 4'd9, 4'd14, 4'd12, SH_LSL, 4'd3);
    w[31:26] = 6'b000011;
    w[7] = 1'b1;
    send_instr(w);
    send_instr(enc_shi(OP_ADD, 1'b1, 4'd15, 4'd15, 5'd0, SH_LSL, 4'd1));
  endtask

  task automatic random_burst(input int unsigned count);
    logic [31:0] w;
    int unsigned sel;
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      w = $urandom();
      if (sel < 25) begin
        // load a small value so register-sourced shift amounts hit the edges
        w = enc_imm(OP_MOV, 1'($urandom_range(1)), 4'($urandom()), 4'($urandom()),
                    4'd0, 8'($urandom_range(66)));
      end else if (sel < 35) begin
        w[11:7] = '0;
      end else if (sel < 45) begin
        w = enc_imm(OP_MOV, 1'($urandom_range(1)), 4'($urandom()), 4'($urandom()),
                    4'($urandom()), 8'($urandom()));
      end
      send_instr(w);
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 0;  recv_stall_pct = 0;  random_burst(320);
    send_idle_pct = 69; recv_stall_pct = 0;  random_burst(320);
    send_idle_pct = 0;  recv_stall_pct = 69; random_burst(320);
    send_idle_pct = 17; recv_stall_pct = 17; random_burst(320);
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_stall_pct = 69;
    random_burst(10);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    random_burst(10);
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        $error("result transaction with no instruction pending: %h", got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.write_enable !== want.write_enable) begin
          $error("write_enable: expected %0d, got %0d", want.write_enable, got.write_enable);
          fail_count++;
        end
        if (got.dest_index !== want.dest_index) begin
          $error("dest_index: expected %0d, got %0d", want.dest_index, got.dest_index);
          fail_count++;
        end
        if (got.write_value !== want.write_value) begin
          $error("write_value: expected %h, got %h", want.write_value, got.write_value);
          fail_count++;
        end
        if (got.flag_negative !== want.flag_negative) begin
          $error("flag_negative: expected %0d, got %0d", want.flag_negative,
                 got.flag_negative);
          fail_count++;
        end
        if (got.flag_zero !== want.flag_zero) begin
          $error("flag_zero: expected %0d, got %0d", want.flag_zero, got.flag_zero);
          fail_count++;
        end
        if (got.flag_carry !== want.flag_carry) begin
          $error("flag_carry: expected %0d, got %0d", want.flag_carry, got.flag_carry);
          fail_count++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("** arm_data_processing_execute: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NumRegs; i++) arch_regs[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 17;
    recv_stall_pct = 17;
    test_reset_state();
    test_immediate_rotate();
    test_alu_ops();
    test_shifter();
    test_ignored_bits();
    test_random_traffic();
    test_drain_pause();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("** arm_data_processing_execute: PASSED **");
    end else begin
      $display("** arm_data_processing_execute: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/arm_dp_pkg.sv
sv/arm_data_processing_execute.sv
bench/tb_arm_data_processing_execute.sv
